// File: design/hrae_pkg.sv
// package for the hall rotor angle estimator core
// types, register indexes, and constants; no dependencies
`timescale 1ns / 1ps
package hrae_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HALL_ANGLES = 3'd0,
    CFG_ANGLE_OFFSET = 3'd1,
    CFG_CORR_ANGLE = 3'd2,
    CFG_MODE_FLAGS = 3'd3,
    CFG_CYCLES_PER_SEC = 3'd4,
    CFG_CURRENT_ZERO = 3'd5,
    CFG_STALL_LIMIT = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_COAST = 2'd0,
    MODE_NOINT = 2'd1,
    MODE_I60 = 2'd2,
    MODE_I360 = 2'd3
  } motor_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HALL,
    ST_SPD_DIV,
    ST_INTERP,
    ST_INT_DIV,
    ST_FINISH,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [2:0] hall_code;
    logic [9:0] phase_current;
    logic [9:0] battery_current;
    logic [7:0] duty_target;
  } in_item_t;

  typedef struct packed {
    logic [7:0] rotor_angle;
    logic [15:0] speed_erps;
    logic [1:0] motor_mode;
    logic [7:0] advance_value;
    logic [9:0] iq_filtered;
  } out_item_t;

  localparam logic [7:0] AdvNeutral = 8'd127;
  localparam logic [7:0] AdvMax = 8'd143;
  localparam logic [7:0] AdvMin = 8'd111;
  localparam logic [15:0] SpeedI360 = 16'd75;
  localparam logic [15:0] SpeedLow = 16'd3;
  localparam logic [15:0] ShortTurn = 16'd20;
  localparam logic [7:0] JitterLimit = 8'd248;

  // hall sector angle from packed register, slot 0..5
  function automatic logic [7:0] angle_of(input logic [47:0] angles,
                                          input logic [2:0] slot);
    logic [7:0] a;
    unique case (slot)
      3'd0: a = angles[7:0];
      3'd1: a = angles[15:8];
      3'd2: a = angles[23:16];
      3'd3: a = angles[31:24];
      3'd4: a = angles[39:32];
      default: a = angles[47:40];
    endcase
    return a;
  endfunction

endpackage

// File: design/hrae_stream_if.sv
// valid/ready stream interface with a generic payload
// depends on nothing
`timescale 1ns / 1ps
interface hrae_stream_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/hall_rotor_angle_estimator_core.sv
// hall rotor angle estimator top level
// depends on hrae_pkg and hrae_stream_if
//
// usage: one request on in_ per PWM tick carries hall code, phase and
// battery current samples and the duty target. one result request on out_
// follows each input with rotor angle, speed, mode, advance and filtered iq.
// cfg_ writes (index, data) load the registers; write only while idle.
// steps: a plain tick passes the hall, interp, finish and output states.
// a hall code 3 adds a mode choice step, or a 16-bit speed division and
// the mode choice when it closes a revolution. an interpolating mode adds
// the 24-bit interpolation division. a stall re-runs the hall step and
// the stall check.
// in_ready returns in the same cycle that the result is loaded, so a new
// item is taken only after the last one is through. one 24-bit restoring
// divider, one quotient bit per cycle, serves both divisions.
// if the receiver stalls, one more request is still taken and computed,
// then held until the output register is free; in_ready stays low meanwhile.
// synchronous active-low reset restores control and config registers to
// defaults (coast mode, advance 127, iq accumulator 4096), not the datapath.
`timescale 1ns / 1ps
module hall_rotor_angle_estimator_core (
  input logic clk,
  input logic rst_n,
  hrae_stream_if.sink in_,
  hrae_stream_if.source out_,
  input logic cfg_we,
  input logic [hrae_pkg::CfgIdxW-1:0] cfg_idx,
  input logic [hrae_pkg::CfgDataW-1:0] cfg_data
);
  import hrae_pkg::*;

  // configuration registers
  logic [47:0] hall_angles_r;
  logic [7:0] angle_offset_r, corr_angle_r;
  logic [4:0] mode_flags_r;
  logic [15:0] cps_r, stall_limit_r;
  logic [9:0] current_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_angles_r <= 48'd234932569189120;
      angle_offset_r <= '0;
      corr_angle_r <= '0;
      mode_flags_r <= '0;
      cps_r <= 16'd15625;
      current_zero_r <= 10'd512;
      stall_limit_r <= 16'd8000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_HALL_ANGLES: hall_angles_r <= cfg_data;
        CFG_ANGLE_OFFSET: angle_offset_r <= cfg_data[7:0];
        CFG_CORR_ANGLE: corr_angle_r <= cfg_data[7:0];
        CFG_MODE_FLAGS: mode_flags_r <= cfg_data[4:0];
        CFG_CYCLES_PER_SEC: cps_r <= cfg_data[15:0];
        CFG_CURRENT_ZERO: current_zero_r <= cfg_data[9:0];
        CFG_STALL_LIMIT: stall_limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // estimator state
  seq_state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [2:0] last_hall_r, last_hall_nxt;
  logic half_r, half_nxt, armed_r, armed_nxt;
  logic [15:0] turn_r, turn_nxt, sector_r, sector_nxt, period_r, period_nxt;
  logic [7:0] hpos_r, hpos_nxt, angle_r, angle_nxt, adv_r, adv_nxt;
  motor_mode_t mode_r, mode_nxt;
  logic [15:0] iqacc_r, iqacc_nxt, speed_r, speed_nxt;
  logic [9:0] iq_r, iq_nxt;
  logic pass_r, pass_nxt;         // second hall evaluation after a stall
  logic stall_r, stall_nxt;
  logic use_turn_r, use_turn_nxt; // interpolate over the whole turn
  // shared divider
  logic [23:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [7:0] ang_r, ang_nxt;
  out_item_t out_r, out_nxt;
  logic out_v_r, out_v_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_hall_r <= '0; half_r <= 1'b0; armed_r <= 1'b0;
      turn_r <= '0; sector_r <= '0; period_r <= '0; hpos_r <= '0;
      mode_r <= MODE_COAST; angle_r <= '0; adv_r <= AdvNeutral;
      iqacc_r <= 16'd4096; iq_r <= '0; speed_r <= '0;
      pass_r <= 1'b0; stall_r <= 1'b0; use_turn_r <= 1'b0;
      out_v_r <= 1'b0; cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_hall_r <= last_hall_nxt; half_r <= half_nxt; armed_r <= armed_nxt;
      turn_r <= turn_nxt; sector_r <= sector_nxt; period_r <= period_nxt;
      hpos_r <= hpos_nxt; mode_r <= mode_nxt; angle_r <= angle_nxt;
      adv_r <= adv_nxt; iqacc_r <= iqacc_nxt; iq_r <= iq_nxt;
      speed_r <= speed_nxt; pass_r <= pass_nxt; stall_r <= stall_nxt;
      use_turn_r <= use_turn_nxt; out_v_r <= out_v_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rem_r <= rem_nxt; quo_r <= quo_nxt; dvs_r <= dvs_nxt;
    ang_r <= ang_nxt; out_r <= out_nxt;
  end

  assign in_.ready = (state_r == ST_IDLE);
  assign out_.valid = out_v_r;
  assign out_.data = out_r;

  logic [24:0] trial;
  logic [15:0] ticks;
  logic [7:0] start, precalc, assumed, jit;
  logic [8:0] corr_end;
  logic [15:0] acc_tmp;

  always_comb begin
    state_nxt = state_r; item_nxt = item_r;
    last_hall_nxt = last_hall_r; half_nxt = half_r; armed_nxt = armed_r;
    turn_nxt = turn_r; sector_nxt = sector_r; period_nxt = period_r;
    hpos_nxt = hpos_r; mode_nxt = mode_r; angle_nxt = angle_r;
    adv_nxt = adv_r; iqacc_nxt = iqacc_r; iq_nxt = iq_r; speed_nxt = speed_r;
    pass_nxt = pass_r; stall_nxt = stall_r; use_turn_nxt = use_turn_r;
    rem_nxt = rem_r; quo_nxt = quo_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    ang_nxt = ang_r; out_nxt = out_r; out_v_nxt = out_v_r;
    trial = {rem_r, quo_r[23]} - {9'd0, dvs_r};
    ticks = use_turn_r ? turn_r : sector_r;
    start = use_turn_r ? angle_of(hall_angles_r, 3'd3) : hpos_r;
    precalc = 8'(start + angle_offset_r + adv_r + 8'd129 + ang_r);
    assumed = 8'(start + ang_r + angle_offset_r);
    jit = 8'(precalc - angle_r);
    corr_end = {1'b0, corr_angle_r} + 9'd4;
    acc_tmp = '0;

    if (out_v_r && out_.ready) out_v_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_.valid) begin
          item_nxt = in_.data;
          pass_nxt = 1'b0;
          stall_nxt = 1'b0;
          state_nxt = ST_HALL;
        end
      end
      // hall transition handling; may launch the speed division
      ST_HALL: begin
        state_nxt = ST_INTERP;
        if (!(item_r.hall_code == last_hall_r && mode_r != MODE_COAST)) begin
          last_hall_nxt = item_r.hall_code;
          if (mode_r == MODE_COAST) mode_nxt = MODE_NOINT;
          sector_nxt = '0;
          unique case (item_r.hall_code)
            3'd3: begin
              hpos_nxt = angle_of(hall_angles_r, 3'd3);
              if (half_r) begin
                half_nxt = 1'b0;
                if (turn_r > ShortTurn) period_nxt = turn_r;
                turn_nxt = '0;
                rem_nxt = '0;
                quo_nxt = {cps_r, 8'd0};
                dvs_nxt = (turn_r > ShortTurn) ? turn_r : period_r;
                cnt_nxt = 5'd16;
                state_nxt = ST_SPD_DIV;
              end else begin
                state_nxt = ST_SPD_DIV;
                cnt_nxt = 5'd0;
                quo_nxt = {8'd0, speed_r};
                dvs_nxt = 16'd1;
              end
            end
            3'd1: hpos_nxt = angle_of(hall_angles_r, 3'd4);
            3'd5: hpos_nxt = angle_of(hall_angles_r, 3'd5);
            3'd4: begin
              half_nxt = 1'b1; armed_nxt = 1'b1;
              hpos_nxt = angle_of(hall_angles_r, 3'd0);
            end
            3'd6: hpos_nxt = angle_of(hall_angles_r, 3'd1);
            3'd2: hpos_nxt = angle_of(hall_angles_r, 3'd2);
            default: sector_nxt = sector_r;
          endcase
        end
      end
      // speed division, then mode choice
      ST_SPD_DIV: begin
        if (cnt_r != 0) begin
          if (!trial[24]) begin
            rem_nxt = trial[23:0];
            quo_nxt = {quo_r[22:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[22:0], quo_r[23]};
            quo_nxt = {quo_r[22:0], 1'b0};
          end
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          // quotient sits in quo_r[15:0]; zero divisor gives zero
          speed_nxt = (dvs_r == 16'd0) ? 16'd0 : quo_r[15:0];
          if (speed_nxt > SpeedI360) mode_nxt = MODE_I360;
          else if (speed_nxt > SpeedLow) mode_nxt = MODE_I60;
          else mode_nxt = MODE_NOINT;
          state_nxt = ST_INTERP;
        end
      end
      // stall check, then set up interpolation
      ST_INTERP: begin
        if (!pass_r && turn_r >= stall_limit_r) begin
          period_nxt = 16'hFFFF; adv_nxt = AdvNeutral; last_hall_nxt = '0;
          speed_nxt = '0; mode_nxt = MODE_COAST;
          pass_nxt = 1'b1;
          state_nxt = ST_HALL;
        end else begin
          ang_nxt = '0;
          use_turn_nxt = 1'b0;
          state_nxt = ST_FINISH;
          if ((mode_r == MODE_I60 || mode_r == MODE_I360) && !mode_flags_r[1]) begin
            use_turn_nxt = mode_flags_r[2] || (mode_flags_r[3] && mode_r == MODE_I360);
            rem_nxt = '0;
            cnt_nxt = 5'd24;
            state_nxt = ST_INT_DIV;
            if ((use_turn_nxt ? turn_r : sector_r) > 16'd255) begin
              quo_nxt = {3'd0, (use_turn_nxt ? turn_r : sector_r), 5'd0};
              dvs_nxt = {3'd0, period_r[15:3]};
            end else begin
              quo_nxt = {(use_turn_nxt ? turn_r : sector_r), 8'd0};
              dvs_nxt = period_r;
            end
          end
        end
      end
      // interpolation division, low 8 quotient bits kept
      ST_INT_DIV: begin
        if (cnt_r != 0) begin
          if (!trial[24]) begin
            rem_nxt = trial[23:0];
            quo_nxt = {quo_r[22:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[22:0], quo_r[23]};
            quo_nxt = {quo_r[22:0], 1'b0};
          end
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          ang_nxt = (dvs_r == 16'd0) ? 8'd0 : quo_r[7:0];
          sector_nxt = sector_r + 16'd1;
          state_nxt = ST_FINISH;
        end
      end
      // angle, anti-jitter, correction window and advance step
      ST_FINISH: begin
        turn_nxt = turn_r + 16'd1;
        if (!mode_flags_r[4] || jit < JitterLimit) angle_nxt = precalc;
        if (armed_r && assumed >= corr_angle_r && {1'b0, assumed} < corr_end) begin
          armed_nxt = 1'b0;
          if (item_r.duty_target > 8'd5) begin
            acc_tmp = iqacc_r - {3'd0, iqacc_r[15:3]};
            acc_tmp = acc_tmp + {6'd0, item_r.phase_current};
            iqacc_nxt = acc_tmp;
            iq_nxt = acc_tmp[12:3];
          end
          if (!mode_flags_r[0]) adv_nxt = AdvNeutral;
          else if (speed_r > SpeedLow &&
                   {1'b0, item_r.battery_current} > {1'b0, current_zero_r} + 11'd3) begin
            if (iq_nxt[9:2] > 8'd128 && adv_r < AdvMax) adv_nxt = adv_r + 8'd1;
            else if (iq_nxt[9:2] < 8'd126 && adv_r > AdvMin) adv_nxt = adv_r - 8'd1;
          end else if (speed_r > SpeedLow &&
                   {1'b0, item_r.battery_current} + 11'd3 < {1'b0, current_zero_r}) begin
            adv_nxt = AdvNeutral;
          end else if (speed_r < SpeedLow) begin
            adv_nxt = AdvNeutral;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_v_r || out_.ready) begin
          out_nxt.rotor_angle = angle_r;
          out_nxt.speed_erps = speed_r;
          out_nxt.motor_mode = mode_r;
          out_nxt.advance_value = adv_r;
          out_nxt.iq_filtered = iq_r;
          out_v_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
